FILE: rtl/core/lfr_pkg.sv
// Shared types and constants for the line framer.
// Used by the front, queue, replay side and top level; depends on nothing.
`default_nettype none

package lfr_pkg;

   localparam int SIZE_W = 7;
   localparam int DROP_W = 16;

   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN  = 8'h0D;

   // A finished line waiting to be replayed from one bank of the store.
   typedef struct packed {
      logic              bank;
      logic [SIZE_W-1:0] size;
      logic [DROP_W-1:0] dropped;
   } line_job_type;

   // Reported by the replay side when a bank may be refilled.
   typedef struct packed {
      logic done;
      logic bank;
   } back_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/lfr_store.sv
// Two-bank line store: one write port, one registered read port.
// Depends on nothing but the address width given by the top level.
`default_nettype none

module lfr_store #(
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W:0]   wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W:0]   rd_addr,
   output logic      [7:0]        rd_data
);

   localparam int DEPTH = 2 << ADDR_W;

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lfr_fifo.sv
// Two-entry queue of finished lines between the front and the replay side.
// Depends on lfr_pkg for the job type.
`default_nettype none

module lfr_fifo
   import lfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire line_job_type push_job,
   input  wire logic         pop,
   output line_job_type      head_job,
   output logic              not_empty
);

   line_job_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);

   // The bank busy bits in the front must keep the queue from ever overfilling.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("line queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("line queue popped while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("line queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/core/lfr_front.sv
// Accepting side: classifies commands, fills the current store bank and
// queues finished lines. Depends on lfr_pkg.
`default_nettype none

module lfr_front
   import lfr_pkg::*;
#(
   parameter int LINE_BYTES = 64,
   parameter int ADDR_W     = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [7:0]        req_in_byte,
   output logic                   wr_en,
   output logic      [ADDR_W:0]   wr_addr,
   output logic      [7:0]        wr_data,
   output logic                   push,
   output line_job_type           push_job,
   input  wire back_status_type   back_status
);

   logic [SIZE_W-1:0] len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              last_cr_ff, last_cr_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              accept;
   logic              end_line;
   logic [SIZE_W-1:0] strip_len;

   always_comb begin
      req_ready = !busy_ff[bank_ff];
      accept    = req_valid && req_ready;
      end_line  = accept && ((req_command == CMD_DATA && req_in_byte == CH_NEWLINE) ||
                             req_command == CMD_FLUSH);
      strip_len = len_ff - {{(SIZE_W-1){1'b0}}, (len_ff != '0) && last_cr_ff};

      len_in     = len_ff;
      ovf_in     = ovf_ff;
      last_cr_in = last_cr_ff;
      drop_in    = drop_ff;
      bank_in    = bank_ff;
      busy_in    = busy_ff;
      wr_en      = 1'b0;
      push       = 1'b0;

      if (end_line) begin
         if (ovf_ff) begin
            if (drop_ff != {DROP_W{1'b1}}) begin
               drop_in = drop_ff + 1'b1;
            end
         end else if (strip_len != '0) begin
            push    = 1'b1;
            bank_in = !bank_ff;
         end
         len_in     = '0;
         ovf_in     = 1'b0;
         last_cr_in = 1'b0;
      end else if (accept) begin
         case (req_command)
            CMD_DATA: begin
               if (!ovf_ff) begin
                  if (len_ff >= SIZE_W'(LINE_BYTES)) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en      = 1'b1;
                     len_in     = len_ff + 1'b1;
                     last_cr_in = (req_in_byte == CH_RETURN);
                  end
               end
            end
            CMD_CLEAR: begin
               len_in     = '0;
               ovf_in     = 1'b0;
               last_cr_in = 1'b0;
               drop_in    = '0;
            end
            default: begin
            end
         endcase
      end

      // The bank being released is always a different one from the bank being
      // claimed, since a claimed bank must have been free.
      if (back_status.done) begin
         busy_in[back_status.bank] = 1'b0;
      end
      if (push) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   assign wr_addr          = {bank_ff, len_ff[ADDR_W-1:0]};
   assign wr_data          = req_in_byte;
   assign push_job.bank    = bank_ff;
   assign push_job.size    = strip_len;
   assign push_job.dropped = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         last_cr_ff <= 1'b0;
         drop_ff    <= '0;
         bank_ff    <= 1'b0;
         busy_ff    <= 2'b00;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         last_cr_ff <= last_cr_in;
         drop_ff    <= drop_in;
         bank_ff    <= bank_in;
         busy_ff    <= busy_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= SIZE_W'(LINE_BYTES))
      else $error("line length beyond store size");

   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff[bank_ff])
      else $error("write into a bank still being replayed");

   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      back_status.done |-> busy_ff[back_status.bank])
      else $error("release of a bank that was not claimed");

endmodule

`default_nettype wire

FILE: rtl/core/lfr_back.sv
// Replay side: takes finished lines from the queue and gives out their bytes
// from the store, one transfer per byte. Depends on lfr_pkg.
`default_nettype none

module lfr_back
   import lfr_pkg::*;
#(
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire line_job_type      head_job,
   input  wire logic              not_empty,
   output logic                   pop,
   output logic                   rd_en,
   output logic      [ADDR_W:0]   rd_addr,
   input  wire logic [7:0]        rd_data,
   output back_status_type        back_status,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [7:0]        rsp_line_byte,
   output logic                   rsp_line_end,
   output logic      [SIZE_W-1:0] rsp_line_size,
   output logic      [DROP_W-1:0] rsp_dropped_lines
);

   typedef enum logic {
      ST_IDLE,
      ST_SHOW
   } back_state_type;

   back_state_type    state_ff, state_in;
   line_job_type      job_ff, job_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              is_last;
   logic              sent;

   always_comb begin
      is_last = (SIZE_W'(idx_ff) + SIZE_W'(1)) == job_ff.size;
      sent    = (state_ff == ST_SHOW) && rsp_ready;

      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = {job_ff.bank, ADDR_W'(idx_ff + 1'b1)};
      back_status.done = 1'b0;
      back_status.bank = job_ff.bank;

      case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               rd_addr  = {head_job.bank, {ADDR_W{1'b0}}};
               job_in   = head_job;
               idx_in   = '0;
               state_in = ST_SHOW;
            end
         end
         ST_SHOW: begin
            if (sent) begin
               if (is_last) begin
                  back_status.done = 1'b1;
                  // Start the next queued line straight away, without a gap.
                  if (not_empty) begin
                     pop     = 1'b1;
                     rd_en   = 1'b1;
                     rd_addr = {head_job.bank, {ADDR_W{1'b0}}};
                     job_in  = head_job;
                     idx_in  = '0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rd_en  = 1'b1;
                  idx_in = ADDR_W'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      job_ff <= job_in;
   end

   assign rsp_valid         = (state_ff == ST_SHOW);
   assign rsp_line_byte     = rd_data;
   assign rsp_line_end      = is_last;
   assign rsp_line_size     = job_ff.size;
   assign rsp_dropped_lines = job_ff.dropped;

endmodule

`default_nettype wire

FILE: rtl/core/line_framer_with_overflow_drop.sv
// A line ended by newline or flush passes the queue and a registered store read before output.
// Throughput: one input transfer per cycle; one output byte per cycle, back to back across lines,
// with rsp_ready high. Input stalls only when both store banks hold lines not yet fully replayed.
// Reset clears length, overflow mark, dropped count, queue and replay state at once.
// The line store itself is not cleared; entries are always written before being read.
`default_nettype none

module line_framer_with_overflow_drop
   import lfr_pkg::*;
#(
   parameter int LINE_BYTES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [7:0]        req_in_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [7:0]        rsp_line_byte,
   output logic                   rsp_line_end,
   output logic      [SIZE_W-1:0] rsp_line_size,
   output logic      [DROP_W-1:0] rsp_dropped_lines
);

   localparam int ADDR_W = $clog2(LINE_BYTES);

   logic              wr_en;
   logic [ADDR_W:0]   wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W:0]   rd_addr;
   logic [7:0]        rd_data;
   logic              push;
   line_job_type      push_job;
   logic              pop;
   line_job_type      head_job;
   logic              not_empty;
   back_status_type   back_status;

   lfr_front #(
      .LINE_BYTES (LINE_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_in_byte (req_in_byte),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .push        (push),
      .push_job    (push_job),
      .back_status (back_status)
   );

   lfr_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lfr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty)
   );

   lfr_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .not_empty         (not_empty),
      .pop               (pop),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .back_status       (back_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_byte     (rsp_line_byte),
      .rsp_line_end      (rsp_line_end),
      .rsp_line_size     (rsp_line_size),
      .rsp_dropped_lines (rsp_dropped_lines)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for line_framer_with_overflow_drop.
// Depends on lfr_pkg and the framer RTL; a scoreboard class predicts every output byte.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lfr_pkg::*;

   localparam int LINE_BYTES = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS = 10;
   localparam int TAIL_CYCLES = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0]        data;
      logic              last;
      logic [SIZE_W-1:0] size;
      logic [DROP_W-1:0] dropped;
   } line_beat_type;

   // Tracks the pending line and the drop counter, and holds the bytes still to come out.
   class line_tracker;
      logic [7:0]        store [LINE_BYTES];
      int                held;
      bit                overflowed;
      logic [DROP_W-1:0] drop_count;
      line_beat_type     owed_bytes [$];
      int                failures;

      function new();
         held = 0;
         overflowed = 0;
         drop_count = '0;
         failures = 0;
      endfunction

      function void close_line();
         int n;
         line_beat_type beat;
         if (overflowed) begin
            if (drop_count != {DROP_W{1'b1}})
               drop_count++;
         end else begin
            n = held;
            if (n > 0 && store[n-1] == CH_RETURN)
               n--;
            for (int k = 0; k < n; k++) begin
               beat.data = store[k];
               beat.last = (k == n - 1);
               beat.size = n[SIZE_W-1:0];
               beat.dropped = drop_count;
               owed_bytes.push_back(beat);
            end
         end
         held = 0;
         overflowed = 0;
      endfunction

      function void note_transfer(logic [1:0] cmd, logic [7:0] b);
         case (cmd)
            CMD_DATA: begin
               if (b == CH_NEWLINE)
                  close_line();
               else if (!overflowed) begin
                  // A byte that finds the store full marks the line, even a carriage return.
                  if (held == LINE_BYTES)
                     overflowed = 1;
                  else begin
                     store[held] = b;
                     held++;
                  end
               end
            end
            CMD_FLUSH: close_line();
            CMD_CLEAR: begin
               held = 0;
               overflowed = 0;
               drop_count = '0;
            end
            default: ;
         endcase
      endfunction

      function void check_byte(logic [7:0] b, logic e, logic [SIZE_W-1:0] sz,
                               logic [DROP_W-1:0] d);
         line_beat_type want;
         if (owed_bytes.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected output byte %h last %b size %0d dropped %0d",
                        b, e, sz, d);
            return;
         end
         want = owed_bytes.pop_front();
         if (want.data !== b || want.last !== e ||
             want.size !== sz || want.dropped !== d) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch: expected %h/%b/%0d/%0d, got %h/%b/%0d/%0d",
                        want.data, want.last, want.size, want.dropped, b, e, sz, d);
         end
      endfunction

      function int pending();
         return owed_bytes.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command = CMD_DATA;
   logic [7:0]        req_in_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_line_byte;
   logic              rsp_line_end;
   logic [SIZE_W-1:0] rsp_line_size;
   logic [DROP_W-1:0] rsp_dropped_lines;

   int          send_idle = 35;
   int          recv_idle = 66;
   int          items_sent = 0;
   int          cycle_count = 0;
   line_tracker tracker;

   line_framer_with_overflow_drop #(.LINE_BYTES(LINE_BYTES)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_line_byte(rsp_line_byte),
      .rsp_line_end(rsp_line_end),
      .rsp_line_size(rsp_line_size),
      .rsp_dropped_lines(rsp_dropped_lines)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Results are checked before the input of the same edge is noted, so order is kept.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_byte(rsp_line_byte, rsp_line_end, rsp_line_size, rsp_dropped_lines);
         if (req_valid && req_ready)
            tracker.note_transfer(req_command, req_in_byte);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_in_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(input int body, input bit with_return, input logic [1:0] ending);
      logic [7:0] b;
      for (int k = 0; k < body; k++) begin
         b = 8'($urandom_range(0, 255));
         if (b == CH_NEWLINE)
            b = 8'h0B;
         send_item(CMD_DATA, b);
      end
      if (with_return)
         send_item(CMD_DATA, CH_RETURN);
      if (ending == CMD_DATA)
         send_item(CMD_DATA, CH_NEWLINE);
      else
         send_item(ending, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_random(input int budget);
      int         stop_at;
      int         pick;
      logic [1:0] ending;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         ending = ($urandom_range(0, 99) < 85) ? CMD_DATA : CMD_FLUSH;
         if (pick < 8)
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         else if (pick < 13)
            send_line($urandom_range(0, 5), 1'b0, CMD_CLEAR);
         else if (pick < 25)
            send_line($urandom_range(8, 20), 1'($urandom_range(0, 1)), ending);
         else
            send_line($urandom_range(0, 7), 1'($urandom_range(0, 1)), ending);
      end
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Short directed lines: trailing return stripped, empty lines, flush, unused code, clear.
      send_item(CMD_DATA, 8'h41);
      send_item(CMD_DATA, 8'hFF);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, CH_RETURN);
      send_item(CMD_DATA, CH_NEWLINE);
      send_item(CMD_DATA, CH_RETURN);
      send_item(CMD_DATA, CH_NEWLINE);
      send_item(CMD_DATA, CH_NEWLINE);
      send_item(CMD_DATA, CH_RETURN);
      send_item(CMD_DATA, CH_RETURN);
      send_item(CMD_DATA, CH_NEWLINE);
      send_item(CMD_DATA, 8'h7E);
      send_item(CMD_FLUSH, 8'h00);
      send_item(CMD_FLUSH, 8'hFF);
      send_item(CMD_UNUSED, CH_NEWLINE);
      send_item(CMD_DATA, 8'h55);
      send_item(CMD_UNUSED, 8'hAA);
      send_item(CMD_FLUSH, CH_NEWLINE);
      send_item(CMD_DATA, 8'h31);
      send_item(CMD_CLEAR, 8'hFF);
      send_item(CMD_DATA, CH_NEWLINE);

      // A carriage return that finds the store full overflows the line.
      send_line(LINE_BYTES, 1'b1, CMD_DATA);
      run_random(PHASE_ITEMS);

      send_idle = 66;
      recv_idle = 35;
      // Overflowed line whose further bytes are ignored, ended by a flush.
      send_line(LINE_BYTES + 3, 1'b0, CMD_FLUSH);
      run_random(PHASE_ITEMS);

      send_idle = 0;
      recv_idle = 0;
      send_line(LINE_BYTES, 1'b0, CMD_DATA);
      run_random(PHASE_ITEMS);
      req_valid <= 1'b0;

      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
